FILE: hdl/lscl_pkg.sv
// Shared types and constants for the LED strip current limiter.
package lscl_pkg;

   localparam int MAX_PIXELS_DEFAULT = 1024;

   localparam int MA_PER_LEVEL  = 46;
   localparam int CHIP_BASE_UA  = 14000;
   localparam int LED_STATIC_UA = 930;
   localparam int UA_PER_MA     = 1000;

   localparam int PIXEL_COUNT_W = 11;
   localparam int BUDGET_W      = 16;
   localparam int LEVEL_W       = 8;
   localparam int SUM_W         = 32;
   localparam int PIX_SUM_W     = 10;   // three levels added
   localparam int PIX_UA_W      = 16;   // that sum times 46
   localparam int BUDGET_UA_W   = 26;
   localparam int BASE_UA_W     = 22;
   localparam int LIMIT_W       = 27;   // signed
   localparam int DIVIDEND_W    = 26;
   localparam int DIVISOR_W     = 24;
   localparam int DIV_STEPS     = DIVIDEND_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = 11'd15;
   localparam logic [BUDGET_W-1:0]      BUDGET_RESET      = 16'd200;
   localparam logic [LEVEL_W-1:0]       BRIGHTNESS_RESET  = 8'd15;
   localparam logic [LEVEL_W-1:0]       LEVEL_MAX         = 8'hff;

   typedef enum logic [1:0] {
      REG_PIXEL_COUNT  = 2'd0,
      REG_POWER_BUDGET = 2'd1,
      REG_BRIGHTNESS   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_FLUSH,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RES_KEEP,
      RES_ZERO,
      RES_QUOT
   } res_sel_type;

   typedef struct packed {
      logic        load_pixel;
      logic        accum;
      logic        div_init;
      logic        div_step;
      logic        out_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic fits;
      logic no_div;
   } status_type;

endpackage

FILE: hdl/led_strip_current_limiter_core.sv
// LED strip current limiter: estimates frame current and lowers brightness to fit a budget.
//
// Input channel (req_*): one item per pixel, three color levels plus frame_end.
// Pixels are taken one per cycle while no frame end is being resolved.
// Result channel (rsp_*): one item per frame, issued for the pixel that carries
// frame_end; other pixels give no result.
// After a frame-end pixel is taken, req_ready stays low through the FLUSH, CHECK
// and FINISH states when the scaled current fits the budget (or no division is
// needed), and also through the 26 steps of the restoring divider when the new
// brightness must be computed. The result is registered in the FINISH state.
// The result register lets pixels of the next frame stream in while a result
// waits on rsp_ready; a second frame end then waits for the register to free.
// Configuration (csr_*): APB-style, registers at 0x0 pixel_count, 0x4
// power_budget, 0x8 brightness; write only while the block is idle.
// Reset (synchronous) restores pixel_count 15, power_budget 200, brightness 15
// and clears both current sums.
module led_strip_current_limiter_core #(
   parameter int MAX_PIXELS = lscl_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lscl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lscl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lscl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lscl_pkg::LEVEL_W-1:0]    req_red_level,
   input  logic [lscl_pkg::LEVEL_W-1:0]    req_green_level,
   input  logic [lscl_pkg::LEVEL_W-1:0]    req_blue_level,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lscl_pkg::LEVEL_W-1:0]    rsp_allowed_brightness,
   output logic                            rsp_was_limited
);
   import lscl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   lscl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   lscl_dpath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .req_red_level          (req_red_level),
      .req_green_level        (req_green_level),
      .req_blue_level         (req_blue_level),
      .rsp_allowed_brightness (rsp_allowed_brightness),
      .rsp_was_limited        (rsp_was_limited),
      .cmd                    (cmd),
      .status                 (status)
   );

endmodule

FILE: hdl/lscl_ctrl.sv
// Controller state machine of the current limiter: handshakes, sequencing, divide count.
module lscl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lscl_pkg::status_type status,
   output lscl_pkg::cmd_type    cmd
);
   import lscl_pkg::*;

   state_type             state_ff, state_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0]  step_cnt_ff, step_cnt_in;
   res_sel_type           res_sel_ff, res_sel_in;
   logic                  accept;
   logic                  out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_frame_end) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.fits || status.no_div) state_in = ST_FINISH;
            else state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // outputs and commands
   always_comb begin
      req_ready    = 1'b0;
      cmd.div_init = 1'b0;
      cmd.div_step = 1'b0;
      cmd.out_load = 1'b0;
      res_sel_in   = res_sel_ff;
      step_cnt_in  = step_cnt_ff;
      case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
         end
         ST_FLUSH: begin
         end
         ST_CHECK: begin
            if (status.fits) res_sel_in = RES_KEEP;
            else if (status.no_div) res_sel_in = RES_ZERO;
            else res_sel_in = RES_QUOT;
            cmd.div_init = 1'b1;
            step_cnt_in  = '0;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_cnt_in  = step_cnt_ff + DIV_CNT_W'(1);
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
         end
      endcase
      cmd.load_pixel = accept;
      cmd.accum      = s1_valid_ff;
      cmd.res_sel    = res_sel_ff;
   end

   assign s1_valid_in  = accept;
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_cnt_ff  <= '0;
         res_sel_ff   <= RES_KEEP;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_cnt_ff  <= step_cnt_in;
         res_sel_ff   <= res_sel_in;
      end
   end

endmodule

FILE: hdl/lscl_dpath.sv
// Datapath of the current limiter: registers, current sums, budget, divider, result.
module lscl_dpath #(
   parameter int MAX_PIXELS = lscl_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lscl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lscl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lscl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic [lscl_pkg::LEVEL_W-1:0]      req_red_level,
   input  logic [lscl_pkg::LEVEL_W-1:0]      req_green_level,
   input  logic [lscl_pkg::LEVEL_W-1:0]      req_blue_level,
   output logic [lscl_pkg::LEVEL_W-1:0]      rsp_allowed_brightness,
   output logic                              rsp_was_limited,
   input  lscl_pkg::cmd_type                 cmd,
   output lscl_pkg::status_type              status
);
   import lscl_pkg::*;

   function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] v,
                                                      input logic [LEVEL_W-1:0] b);
      logic [16:0] p;
      p = {9'b0, v} * ({9'b0, b} + 17'd1);
      return p[15:8];
   endfunction

   logic [PIXEL_COUNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic [BUDGET_W-1:0]      budget_ff, budget_in;
   logic [LEVEL_W-1:0]       bright_ff, bright_in;
   logic [PIX_SUM_W-1:0]     s1_scaled_ff, s1_scaled_in;
   logic [PIX_SUM_W-1:0]     s1_full_ff, s1_full_in;
   logic [SUM_W-1:0]         scaled_sum_ff, scaled_sum_in;
   logic [SUM_W-1:0]         full_sum_ff, full_sum_in;
   logic signed [LIMIT_W-1:0] limit_ff, limit_in;
   logic [DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]    quot_ff, quot_in;
   logic [LEVEL_W-1:0]       out_bright_ff, out_bright_in;
   logic                     out_limited_ff, out_limited_in;

   logic                     csr_write;
   reg_index_type            csr_index;
   logic [PIX_UA_W-1:0]      pix_scaled_ua, pix_full_ua;
   logic [SUM_W:0]           scaled_add, full_add;
   logic [BUDGET_UA_W-1:0]   budget_ua;
   logic [BASE_UA_W-1:0]     base_ua;
   logic [DIVISOR_W-1:0]     divisor;
   logic [DIVISOR_W:0]       rem_shift;
   logic [DIVISOR_W+1:0]     trial;
   logic [LEVEL_W-1:0]       quot_clamped;
   logic [LEVEL_W-1:0]       result;

   // configuration port
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      pixel_count_in = pixel_count_ff;
      budget_in      = budget_ff;
      bright_in      = bright_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PIXEL_COUNT: begin
               if (int'(csr_pwdata[PIXEL_COUNT_W-1:0]) > MAX_PIXELS)
                  pixel_count_in = PIXEL_COUNT_W'(MAX_PIXELS);
               else
                  pixel_count_in = csr_pwdata[PIXEL_COUNT_W-1:0];
            end
            REG_POWER_BUDGET: begin
               budget_in = csr_pwdata[BUDGET_W-1:0];
            end
            REG_BRIGHTNESS: begin
               bright_in = csr_pwdata[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (cmd.out_load && cmd.res_sel != RES_KEEP) begin
         // limiter lowers the global intensity for later frames
         bright_in = result;
      end
   end

   always_comb begin
      case (csr_index)
         REG_PIXEL_COUNT:  csr_prdata = CSR_DATA_W'(pixel_count_ff);
         REG_POWER_BUDGET: csr_prdata = CSR_DATA_W'(budget_ff);
         REG_BRIGHTNESS:   csr_prdata = CSR_DATA_W'(bright_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // pixel stage: scale each level by brightness + 1, then add the three
   assign s1_scaled_in = PIX_SUM_W'(scale_level(req_red_level, bright_ff))
                       + PIX_SUM_W'(scale_level(req_green_level, bright_ff))
                       + PIX_SUM_W'(scale_level(req_blue_level, bright_ff));
   assign s1_full_in   = PIX_SUM_W'(req_red_level) + PIX_SUM_W'(req_green_level)
                       + PIX_SUM_W'(req_blue_level);

   // accumulate stage, saturating at all ones
   assign pix_scaled_ua = PIX_UA_W'(s1_scaled_ff) * PIX_UA_W'(MA_PER_LEVEL);
   assign pix_full_ua   = PIX_UA_W'(s1_full_ff) * PIX_UA_W'(MA_PER_LEVEL);
   assign scaled_add    = {1'b0, scaled_sum_ff} + (SUM_W+1)'(pix_scaled_ua);
   assign full_add      = {1'b0, full_sum_ff} + (SUM_W+1)'(pix_full_ua);

   always_comb begin
      scaled_sum_in = scaled_sum_ff;
      full_sum_in   = full_sum_ff;
      if (cmd.out_load) begin
         scaled_sum_in = '0;
         full_sum_in   = '0;
      end else if (cmd.accum) begin
         scaled_sum_in = scaled_add[SUM_W] ? '1 : scaled_add[SUM_W-1:0];
         full_sum_in   = full_add[SUM_W] ? '1 : full_add[SUM_W-1:0];
      end
   end

   // budget left after the static load, in microamps
   assign budget_ua = BUDGET_UA_W'(BUDGET_UA_W'(budget_ff) * BUDGET_UA_W'(UA_PER_MA));
   assign base_ua   = BASE_UA_W'(CHIP_BASE_UA)
                    + BASE_UA_W'(BASE_UA_W'(pixel_count_ff) * BASE_UA_W'(LED_STATIC_UA));
   assign limit_in  = $signed({1'b0, budget_ua}) - $signed(LIMIT_W'(base_ua));

   assign divisor       = full_sum_ff[SUM_W-1:8];
   assign status.fits   = !limit_ff[LIMIT_W-1]
                       && (scaled_sum_ff <= SUM_W'(limit_ff[DIVIDEND_W-1:0]));
   assign status.no_div = limit_ff[LIMIT_W-1] || (divisor == '0);

   // restoring divider, one quotient bit per step
   assign rem_shift = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.div_init) begin
         rem_in  = '0;
         quot_in = limit_ff[DIVIDEND_W-1:0];
      end else if (cmd.div_step) begin
         if (!trial[DIVISOR_W+1]) begin
            rem_in  = trial[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[DIVISOR_W-1:0];
            quot_in = {quot_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   // quotient minus one, clamped to the level range
   always_comb begin
      if (quot_ff == '0)
         quot_clamped = '0;
      else if (quot_ff > DIVIDEND_W'(256))
         quot_clamped = LEVEL_MAX;
      else
         quot_clamped = LEVEL_W'(quot_ff - DIVIDEND_W'(1));
   end

   always_comb begin
      case (cmd.res_sel)
         RES_KEEP: result = bright_ff;
         RES_ZERO: result = '0;
         RES_QUOT: result = quot_clamped;
         default:  result = '0;
      endcase
   end

   assign out_bright_in  = cmd.out_load ? result : out_bright_ff;
   assign out_limited_in = cmd.out_load ? (cmd.res_sel != RES_KEEP) : out_limited_ff;

   assign rsp_allowed_brightness = out_bright_ff;
   assign rsp_was_limited        = out_limited_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PIXEL_COUNT_RESET;
         budget_ff      <= BUDGET_RESET;
         bright_ff      <= BRIGHTNESS_RESET;
         scaled_sum_ff  <= '0;
         full_sum_ff    <= '0;
      end else begin
         pixel_count_ff <= pixel_count_in;
         budget_ff      <= budget_in;
         bright_ff      <= bright_in;
         scaled_sum_ff  <= scaled_sum_in;
         full_sum_ff    <= full_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         s1_scaled_ff <= s1_scaled_in;
         s1_full_ff   <= s1_full_in;
      end
      limit_ff       <= limit_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      out_bright_ff  <= out_bright_in;
      out_limited_ff <= out_limited_in;
   end

endmodule
